@@ src/fbde_pkg.sv @@
`default_nettype none
package fbde_pkg;

  localparam int BYTE_BITS = 8;

  localparam logic [3:0] OP_PIXEL  = 4'd0;
  localparam logic [3:0] OP_HLINE  = 4'd1;
  localparam logic [3:0] OP_VLINE  = 4'd2;
  localparam logic [3:0] OP_FRECT  = 4'd3;
  localparam logic [3:0] OP_BRECT  = 4'd4;
  localparam logic [3:0] OP_CLEAR  = 4'd5;
  localparam logic [3:0] OP_FILL   = 4'd6;
  localparam logic [3:0] OP_INVERT = 4'd7;
  localparam logic [3:0] OP_READ   = 4'd8;

  localparam logic CFG_LINE_PIXELS = 1'b0;
  localparam logic CFG_FRAME_ROWS  = 1'b1;

  typedef struct packed {
    logic [3:0] opcode;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] span_w;
    logic [7:0] span_h;
    logic [7:0] border_thick;
    logic       pixel_value;
    logic [8:0] byte_addr;
  } cmd_t;

  // one line segment; coordinates may fall below zero for border sides
  typedef struct packed {
    logic signed [11:0] lx;
    logic signed [11:0] ly;
    logic [7:0]         len;
    logic               vert;
  } line_t;

  typedef struct packed {
    logic [8:0] eff_w;
    logic [6:0] eff_h;
    logic [5:0] wbytes;
  } geom_cfg_t;

endpackage
`default_nettype wire

@@ src/fbde_mem.sv @@
`default_nettype none
module fbde_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

@@ src/fbde_geom.sv @@
`default_nettype none
module fbde_geom
  import fbde_pkg::*;
#(
  parameter int AW = 9
) (
  input  wire cmd_t       cmd_i,
  input  wire logic [7:0] idx_i,
  input  wire logic [1:0] sub_i,
  input  wire geom_cfg_t  cfg_i,
  input  wire line_t      cur_i,
  input  wire logic [7:0] step_i,
  output line_t         line_o,
  output logic          reject_o,
  output logic [AW-1:0] addr_o,
  output logic [7:0]    mask_o
);

  logic signed [11:0] x, y, w, h, i;
  logic signed [11:0] ex, ey, ww, hh, px, py;
  logic               in_start, in_end;
  logic [12:0]        prod;

  always_comb begin
    x  = $signed({4'd0, cmd_i.pos_x});
    y  = $signed({4'd0, cmd_i.pos_y});
    w  = $signed({4'd0, cmd_i.span_w});
    h  = $signed({4'd0, cmd_i.span_h});
    i  = $signed({4'd0, idx_i});
    ww = $signed({3'd0, cfg_i.eff_w});
    hh = $signed({5'd0, cfg_i.eff_h});
    line_o = '{lx: x, ly: y, len: cmd_i.span_w, vert: 1'b0};
    unique case (cmd_i.opcode)
      OP_PIXEL: line_o.len = 8'd1;
      OP_VLINE: line_o.vert = 1'b1;
      OP_FRECT: line_o.ly = y + i;
      OP_BRECT: begin
        unique case (sub_i)
          2'd0: line_o.ly = y + i;
          2'd1: line_o.ly = y + h - 12'sd1 - i;
          2'd2: line_o = '{lx: x + i, ly: y, len: cmd_i.span_h, vert: 1'b1};
          default: line_o = '{lx: x + w - 12'sd1 - i, ly: y, len: cmd_i.span_h, vert: 1'b1};
        endcase
      end
      default: ;
    endcase

    in_start = (line_o.lx >= 0) && (line_o.lx < ww) && (line_o.ly >= 0) && (line_o.ly < hh);
    ex = line_o.lx + $signed({4'd0, line_o.len}) - 12'sd1;
    ey = line_o.ly + $signed({4'd0, line_o.len});
    if (line_o.vert) begin
      in_end = (ey <= hh);
    end else begin
      in_end = (ex >= 0) && (ex < ww);
    end
    reject_o = !(in_start && in_end);

    px = cur_i.vert ? cur_i.lx : cur_i.lx + $signed({4'd0, step_i});
    py = cur_i.vert ? cur_i.ly + $signed({4'd0, step_i}) : cur_i.ly;
    prod   = 13'(py[6:0] * cfg_i.wbytes) + 13'(px[7:3]);
    addr_o = prod[AW-1:0];
    mask_o = 8'h80 >> px[2:0];
  end

endmodule
`default_nettype wire

@@ src/mono_framebuffer_draw_engine_core.sv @@
`default_nettype none
// 1 bpp framebuffer drawing engine, one command per transfer, one result per command.
// Pixel, line and rectangle commands check each line segment (ST_LCHK), then read (ST_PRD)
// and write (ST_PWR) each drawn pixel via the read and write ports of the frame memory.
// Clear and fill write each active byte (ST_SWEEP), invert reads then writes it (ST_IRD,
// ST_IWR), read byte reads one byte (ST_RD, ST_RDW). Each command also passes idle, decode
// (ST_START) and result (ST_DONE); a result held on the output waits for m_axis_tready.
// After reset a clearing pass zeroes all MAX_WIDTH/8*MAX_HEIGHT bytes before any command.
module mono_framebuffer_draw_engine_core
  import fbde_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // pos_x, pos_y, span_w, span_h, border_thick, pixel_value, byte_addr, zero pad
  input  wire logic [55:0] s_axis_tdata,
  // opcode
  input  wire logic [3:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_data
  output logic [7:0]       m_axis_tdata,
  // clipped
  output logic             m_axis_tuser,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  localparam int STORE_BYTES = (MAX_WIDTH / BYTE_BITS) * MAX_HEIGHT;
  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [8:0] WCAP = 9'((MAX_WIDTH / BYTE_BITS) * BYTE_BITS);
  localparam logic [6:0] HCAP = 7'(MAX_HEIGHT);
  localparam logic [12:0] LAST_BYTE = 13'(STORE_BYTES - 1);

  localparam logic [3:0] ST_CLR   = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_START = 4'd2;
  localparam logic [3:0] ST_LCHK  = 4'd3;
  localparam logic [3:0] ST_PRD   = 4'd4;
  localparam logic [3:0] ST_PWR   = 4'd5;
  localparam logic [3:0] ST_SWEEP = 4'd6;
  localparam logic [3:0] ST_IRD   = 4'd7;
  localparam logic [3:0] ST_IWR   = 4'd8;
  localparam logic [3:0] ST_RD    = 4'd9;
  localparam logic [3:0] ST_RDW   = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  logic [3:0]  state_q, state_d;
  logic [7:0]  line_pixels_q;
  logic [5:0]  frame_rows_q;
  cmd_t        cmd_q, cmd_d;
  line_t       cur_q, cur_d, line;
  logic [7:0]  idx_q, idx_d, cnt_q, cnt_d, step_q, step_d;
  logic [1:0]  sub_q, sub_d;
  logic [12:0] k_q, k_d, nbytes;
  logic        clip_q, clip_d;
  logic [7:0]  rd_q, rd_d;
  logic        out_vld_q, out_vld_d, out_clip_q;
  logic [7:0]  out_rd_q;
  geom_cfg_t   gcfg;
  logic [8:0]  lpm;
  logic        reject;
  logic [AW-1:0] paddr, raddr, waddr;
  logic [7:0]  pmask, rdata, wdata;
  logic        we, last_line, last_sub;
  logic [7:0]  t1, tmax, tc;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_rd_q;
  assign m_axis_tuser  = out_clip_q;

  always_comb begin
    lpm         = {1'b0, line_pixels_q & 8'hF8};
    gcfg.eff_w  = (lpm > WCAP) ? WCAP : lpm;
    gcfg.eff_h  = ({1'b0, frame_rows_q} > HCAP) ? HCAP : {1'b0, frame_rows_q};
    gcfg.wbytes = gcfg.eff_w[8:3];
    nbytes      = 13'(gcfg.wbytes * gcfg.eff_h);
  end

  fbde_geom #(.AW(AW)) u_geom (
    .cmd_i   (cmd_q),
    .idx_i   (idx_q),
    .sub_i   (sub_q),
    .cfg_i   (gcfg),
    .cur_i   (cur_q),
    .step_i  (step_q),
    .line_o  (line),
    .reject_o(reject),
    .addr_o  (paddr),
    .mask_o  (pmask)
  );

  fbde_mem #(.DEPTH(STORE_BYTES), .AW(AW)) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    t1   = (cmd_q.border_thick == 8'd0) ? 8'd1 : cmd_q.border_thick;
    tmax = (cmd_q.span_w > cmd_q.span_h) ? cmd_q.span_w : cmd_q.span_h;
    tc   = (t1 > tmax) ? tmax : t1;
    last_sub  = (cmd_q.opcode != OP_BRECT) || (sub_q == 2'd3);
    last_line = last_sub && (idx_q + 8'd1 == cnt_q);
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    step_d    = step_q;
    sub_d     = sub_q;
    k_d       = k_q;
    clip_d    = clip_q;
    rd_d      = rd_q;
    out_vld_d = out_vld_q;
    we        = 1'b0;
    waddr     = k_q[AW-1:0];
    wdata     = 8'h00;
    raddr     = paddr;
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    unique case (state_q)
      ST_CLR: begin
        we  = 1'b1;
        k_d = k_q + 13'd1;
        if (k_q == LAST_BYTE) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d = '{opcode: s_axis_tuser, pos_x: s_axis_tdata[7:0],
                    pos_y: s_axis_tdata[15:8], span_w: s_axis_tdata[23:16],
                    span_h: s_axis_tdata[31:24], border_thick: s_axis_tdata[39:32],
                    pixel_value: s_axis_tdata[40], byte_addr: s_axis_tdata[49:41]};
          state_d = ST_START;
        end
      end
      ST_START: begin
        clip_d = 1'b0;
        rd_d   = 8'h00;
        idx_d  = 8'd0;
        sub_d  = 2'd0;
        k_d    = 13'd0;
        priority if (cmd_q.opcode <= OP_BRECT) begin
          cnt_d = (cmd_q.opcode == OP_FRECT) ? cmd_q.span_h :
                  (cmd_q.opcode == OP_BRECT) ? tc : 8'd1;
          state_d = (cnt_d == 8'd0) ? ST_DONE : ST_LCHK;
        end else if (cmd_q.opcode == OP_CLEAR || cmd_q.opcode == OP_FILL) begin
          state_d = (nbytes == 13'd0) ? ST_DONE : ST_SWEEP;
        end else if (cmd_q.opcode == OP_INVERT) begin
          state_d = (nbytes == 13'd0) ? ST_DONE : ST_IRD;
        end else if (cmd_q.opcode == OP_READ) begin
          state_d = (32'(cmd_q.byte_addr) < STORE_BYTES) ? ST_RD : ST_DONE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_LCHK: begin
        if (reject || line.len == 8'd0) begin
          if (reject) begin
            clip_d = 1'b1;
          end
          if (last_line) begin
            state_d = ST_DONE;
          end else if (!last_sub) begin
            sub_d = sub_q + 2'd1;
          end else begin
            sub_d = 2'd0;
            idx_d = idx_q + 8'd1;
          end
        end else begin
          cur_d   = line;
          step_d  = 8'd0;
          state_d = ST_PRD;
        end
      end
      ST_PRD: begin
        state_d = ST_PWR;
      end
      ST_PWR: begin
        we     = 1'b1;
        waddr  = paddr;
        wdata  = ((cmd_q.opcode != OP_PIXEL) || cmd_q.pixel_value) ?
                 (rdata | pmask) : (rdata & ~pmask);
        step_d = step_q + 8'd1;
        if (step_q + 8'd1 != cur_q.len) begin
          state_d = ST_PRD;
        end else if (last_line) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_LCHK;
          if (!last_sub) begin
            sub_d = sub_q + 2'd1;
          end else begin
            sub_d = 2'd0;
            idx_d = idx_q + 8'd1;
          end
        end
      end
      ST_SWEEP: begin
        we    = 1'b1;
        wdata = (cmd_q.opcode == OP_FILL) ? 8'hFF : 8'h00;
        k_d   = k_q + 13'd1;
        if (k_q + 13'd1 == nbytes) begin
          state_d = ST_DONE;
        end
      end
      ST_IRD: begin
        raddr   = k_q[AW-1:0];
        state_d = ST_IWR;
      end
      ST_IWR: begin
        we    = 1'b1;
        wdata = ~rdata;
        k_d   = k_q + 13'd1;
        state_d = (k_q + 13'd1 == nbytes) ? ST_DONE : ST_IRD;
      end
      ST_RD: begin
        raddr   = AW'(32'(cmd_q.byte_addr));
        state_d = ST_RDW;
      end
      ST_RDW: begin
        rd_d    = rdata;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLR;
      k_q           <= '0;
      out_vld_q     <= 1'b0;
      line_pixels_q <= 8'd64;
      frame_rows_q  <= 6'd32;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_LINE_PIXELS: line_pixels_q <= cfg_data_i;
          CFG_FRAME_ROWS:  frame_rows_q  <= cfg_data_i[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    cur_q  <= cur_d;
    idx_q  <= idx_d;
    cnt_q  <= cnt_d;
    step_q <= step_d;
    sub_q  <= sub_d;
    clip_q <= clip_d;
    rd_q   <= rd_d;
    if (state_q == ST_DONE && out_vld_d && !out_vld_q) begin
      out_rd_q   <= rd_q;
      out_clip_q <= clip_q;
    end else if (state_q == ST_DONE && out_vld_q && m_axis_tready) begin
      out_rd_q   <= rd_q;
      out_clip_q <= clip_q;
    end
  end

endmodule
`default_nettype wire
